// File: design/mrf_pkg.sv
`timescale 1ns / 1ps
// Package for the median range finder: default sizes, cell operation codes,
// sequencer states and the statistics control bundle. No dependencies.
package mrf_pkg;

  localparam int unsigned MaxItemsDef  = 256;
  localparam int unsigned ValueBitsDef = 16;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_SHIFT
  } cell_op_e;

  typedef enum logic {
    ST_IDLE,
    ST_DRAIN
  } mrf_state_e;

  // Position flags for one drain step, relative to the two median positions.
  typedef struct packed {
    logic step;
    logic first;
    logic at_lo;
    logic at_hi;
    logic past_lo;
    logic past_hi;
  } stat_ctrl_t;

endpackage

// File: design/mrf_cell.sv
`timescale 1ns / 1ps
// One compare-and-insert cell of the sorting chain.
// Depends on mrf_pkg (cell_op_e).
module mrf_cell
  import mrf_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef
) (
  input  logic                  clk_i,
  input  cell_op_e              op_i,
  input  logic                  occupied_i,
  input  logic [VALUE_BITS-1:0] sample_i,
  input  logic                  left_gt_i,
  input  logic [VALUE_BITS-1:0] left_data_i,
  input  logic [VALUE_BITS-1:0] right_data_i,
  output logic                  gt_o,
  output logic [VALUE_BITS-1:0] data_o
);

  logic [VALUE_BITS-1:0] data_q, data_d;

  // Empty cells count as greater, so the new sample lands at the first of them.
  assign gt_o   = !occupied_i || (data_q > sample_i);
  assign data_o = data_q;

  always_comb begin
    data_d = data_q;
    case (op_i)
      CELL_INSERT: begin
        if (left_gt_i) begin
          data_d = left_data_i;   // make room: advance the larger value
        end else if (gt_o) begin
          data_d = sample_i;
        end
      end
      CELL_SHIFT:  data_d = right_data_i;
      default:     data_d = data_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

endmodule

// File: design/mrf_stat.sv
`timescale 1ns / 1ps
// Median capture and in-range count over the values drained from the chain.
// Depends on mrf_pkg (stat_ctrl_t).
module mrf_stat
  import mrf_pkg::*;
#(
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  parameter int unsigned CNT_BITS   = 9
) (
  input  logic                  clk_i,
  input  stat_ctrl_t            ctrl_i,
  input  logic [VALUE_BITS-1:0] head_i,
  output logic [VALUE_BITS-1:0] lo_o,
  output logic [VALUE_BITS-1:0] hi_o,
  output logic [CNT_BITS-1:0]   cnt_o
);

  logic [VALUE_BITS-1:0] prev_q, prev_d, lo_q, lo_d, hi_q, hi_d;
  logic [CNT_BITS-1:0]   run_q, run_d, cnt_q, cnt_d;

  always_comb begin
    prev_d = prev_q;
    run_d  = run_q;
    lo_d   = lo_q;
    hi_d   = hi_q;
    cnt_d  = cnt_q;
    if (ctrl_i.step) begin
      prev_d = head_i;
      // length of the run of equal values ending here
      if (!ctrl_i.first && (head_i == prev_q)) begin
        run_d = run_q + CNT_BITS'(1);
      end else begin
        run_d = CNT_BITS'(1);
      end
      if (ctrl_i.at_lo) begin
        lo_d  = head_i;
        cnt_d = run_d;
      end else if (ctrl_i.past_lo && !ctrl_i.past_hi) begin
        cnt_d = cnt_q + CNT_BITS'(1);
      end else if (ctrl_i.past_hi && (head_i == hi_q)) begin
        cnt_d = cnt_q + CNT_BITS'(1);
      end
      if (ctrl_i.at_hi) begin
        hi_d = head_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    prev_q <= prev_d;
    run_q  <= run_d;
    lo_q   <= lo_d;
    hi_q   <= hi_d;
    cnt_q  <= cnt_d;
  end

  assign lo_o  = lo_q;
  assign hi_o  = hi_q;
  assign cnt_o = cnt_q;

endmodule

// File: design/median_range_finder.sv
`timescale 1ns / 1ps
// Median range finder: sorting chain of insert cells plus drain-time statistics.
// After the closing beat is taken the stored values are drained and the result
// is strobed by done_o, which is high for one cycle and cannot be stalled.
// Throughput: one sample a cycle while filling; busy stays high during the drain.
// Reset (rst_ni low, asynchronous) empties the chain and clears overflow.
// Depends on mrf_pkg, mrf_cell and mrf_stat.
module median_range_finder
  import mrf_pkg::*;
#(
  parameter int unsigned MAX_ITEMS  = MaxItemsDef,
  parameter int unsigned VALUE_BITS = ValueBitsDef,
  localparam int unsigned CntBits   = $clog2(MAX_ITEMS + 1)
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  logic [VALUE_BITS-1:0] value_i,
  input  logic                  last_i,
  output logic                  done_o,
  output logic [VALUE_BITS-1:0] lower_median_o,
  output logic [CntBits-1:0]    in_range_count_o,
  output logic [VALUE_BITS:0]   candidate_count_o,
  output logic                  overflow_o
);

  mrf_state_e state_q, state_d;

  logic [CntBits-1:0] count_q, count_d;   // values held in the chain
  logic [CntBits-1:0] idx_q, idx_d;       // drain position
  logic               ovf_q, ovf_d;
  logic               ovf_out_q, ovf_out_d;
  logic               done_q, done_d;

  logic               beat;
  logic               full;
  logic               final_step;
  logic [CntBits-1:0] lo_pos, hi_pos, last_pos;
  cell_op_e           op;
  stat_ctrl_t         sctrl;

  logic [VALUE_BITS-1:0] cell_data [MAX_ITEMS];
  logic                  cell_gt   [MAX_ITEMS];

  logic [VALUE_BITS-1:0] lo_val, hi_val;
  logic [CntBits-1:0]    cnt_val;

  assign beat       = start && !busy;
  assign full       = (count_q == CntBits'(MAX_ITEMS));
  assign last_pos   = count_q - CntBits'(1);
  assign lo_pos     = last_pos >> 1;
  assign hi_pos     = count_q >> 1;
  assign final_step = (state_q == ST_DRAIN) && (idx_q == last_pos);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (beat && last_i) state_d = ST_DRAIN;
      ST_DRAIN: if (final_step) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  // Outputs and datapath control of the sequencer
  always_comb begin
    op        = CELL_HOLD;
    count_d   = count_q;
    idx_d     = idx_q;
    ovf_d     = ovf_q;
    ovf_out_d = ovf_out_q;
    done_d    = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        idx_d = '0;
        if (beat) begin
          if (full) begin
            ovf_d = 1'b1;               // drop the sample, note the overflow
          end else begin
            op      = CELL_INSERT;
            count_d = count_q + CntBits'(1);
          end
        end
      end
      ST_DRAIN: begin
        op    = CELL_SHIFT;             // advance every value one cell to the head
        idx_d = idx_q + CntBits'(1);
        if (final_step) begin
          done_d    = 1'b1;
          ovf_out_d = ovf_q;
          ovf_d     = 1'b0;
          count_d   = '0;
        end
      end
      default: op = CELL_HOLD;
    endcase
  end

  assign sctrl.step    = (state_q == ST_DRAIN);
  assign sctrl.first   = (idx_q == '0);
  assign sctrl.at_lo   = (idx_q == lo_pos);
  assign sctrl.at_hi   = (idx_q == hi_pos);
  assign sctrl.past_lo = (idx_q > lo_pos);
  assign sctrl.past_hi = (idx_q > hi_pos);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      count_q   <= '0;
      idx_q     <= '0;
      ovf_q     <= 1'b0;
      ovf_out_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      idx_q     <= idx_d;
      ovf_q     <= ovf_d;
      ovf_out_q <= ovf_out_d;
      done_q    <= done_d;
    end
  end

  // Sorting chain: cell 0 holds the smallest value.
  for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
    logic                  left_gt;
    logic [VALUE_BITS-1:0] left_data, right_data;
    if (i == 0) begin : g_head
      assign left_gt   = 1'b0;
      assign left_data = '0;
    end else begin : g_body
      assign left_gt   = cell_gt[i-1];
      assign left_data = cell_data[i-1];
    end
    if (i == MAX_ITEMS - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_mid
      assign right_data = cell_data[i+1];
    end

    mrf_cell #(
      .VALUE_BITS(VALUE_BITS)
    ) u_cell (
      .clk_i       (clk_i),
      .op_i        (op),
      .occupied_i  (CntBits'(i) < count_q),
      .sample_i    (value_i),
      .left_gt_i   (left_gt),
      .left_data_i (left_data),
      .right_data_i(right_data),
      .gt_o        (cell_gt[i]),
      .data_o      (cell_data[i])
    );
  end

  mrf_stat #(
    .VALUE_BITS(VALUE_BITS),
    .CNT_BITS  (CntBits)
  ) u_stat (
    .clk_i (clk_i),
    .ctrl_i(sctrl),
    .head_i(cell_data[0]),
    .lo_o  (lo_val),
    .hi_o  (hi_val),
    .cnt_o (cnt_val)
  );

  assign busy              = (state_q == ST_DRAIN);
  assign done_o            = done_q;
  assign lower_median_o    = lo_val;
  assign in_range_count_o  = cnt_val;
  assign candidate_count_o = {1'b0, hi_val} - {1'b0, lo_val} + (VALUE_BITS + 1)'(1);
  assign overflow_o        = ovf_out_q;

endmodule

// File: sim/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for median_range_finder: random and directed sample sets,
// checked against an in-bench sorting predictor. Depends on mrf_pkg and the RTL.
module testbench;
  import mrf_pkg::*;

  localparam int unsigned Cap        = MaxItemsDef;
  localparam int unsigned VBits      = ValueBitsDef;
  localparam int unsigned CntW       = $clog2(MaxItemsDef + 1);
  localparam int unsigned CycleLimit = 200000;
  localparam int unsigned ReportMax  = 10;

  // How sample values are drawn for one set.
  localparam int ValFull   = 0;
  localparam int ValNarrow = 1;
  localparam int ValEdge   = 2;

  typedef struct {
    logic [VBits-1:0] value;
    logic             last;
    int unsigned      idle_pct;
  } sample_beat_t;

  typedef struct {
    logic [VBits-1:0] lower_median;
    logic [CntW-1:0]  in_range;
    logic [VBits:0]   candidates;
    logic             overflow;
  } median_result_t;

  logic             clk_i   = 1'b0;
  logic             rst_ni  = 1'b0;
  logic             start   = 1'b0;
  logic [VBits-1:0] value_i = '0;
  logic             last_i  = 1'b0;
  logic             busy;
  logic             done_o;
  logic [VBits-1:0] lower_median_o;
  logic [CntW-1:0]  in_range_count_o;
  logic [VBits:0]   candidate_count_o;
  logic             overflow_o;

  median_range_finder dut (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .start             (start),
    .busy              (busy),
    .value_i           (value_i),
    .last_i            (last_i),
    .done_o            (done_o),
    .lower_median_o    (lower_median_o),
    .in_range_count_o  (in_range_count_o),
    .candidate_count_o (candidate_count_o),
    .overflow_o        (overflow_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  sample_beat_t   pending_beats[$];
  median_result_t expected_medians[$];

  // Predictor state: the sorted store of the open set.
  logic [VBits-1:0] sorted_vals[Cap];
  int unsigned      held_count     = 0;
  logic             set_overflowed = 1'b0;

  int unsigned beats_queued    = 0;
  int unsigned beats_accepted  = 0;
  int unsigned sets_closed     = 0;
  int unsigned overflow_sets   = 0;
  int unsigned results_checked = 0;
  int unsigned mismatches      = 0;
  int unsigned cycle_count     = 0;

  // Insert one accepted sample and, on the closing beat, work out the result.
  function automatic void take_sample(logic [VBits-1:0] v, logic closes);
    int unsigned    pos;
    int unsigned    hits;
    logic [VBits-1:0] lo;
    logic [VBits-1:0] hi;
    median_result_t r;
    if (held_count >= Cap) begin
      // store full: drop the sample, remember the overflow
      set_overflowed = 1'b1;
    end else begin
      pos = held_count;
      while (pos > 0 && sorted_vals[pos-1] > v) begin
        sorted_vals[pos] = sorted_vals[pos-1];
        pos--;
      end
      sorted_vals[pos] = v;
      held_count++;
    end
    if (closes) begin
      lo   = sorted_vals[(held_count - 1) / 2];
      hi   = sorted_vals[held_count / 2];
      hits = 0;
      for (int i = 0; i < held_count; i++) begin
        if (sorted_vals[i] >= lo && sorted_vals[i] <= hi) hits++;
      end
      r.lower_median = lo;
      r.in_range     = hits[CntW-1:0];
      r.candidates   = {1'b0, hi} - {1'b0, lo} + 1'b1;
      r.overflow     = set_overflowed;
      expected_medians.insert(expected_medians.size(), r);
      if (set_overflowed) overflow_sets++;
      sets_closed++;
      held_count     = 0;
      set_overflowed = 1'b0;
    end
  endfunction

  // Driver: note the beat taken at this edge, then present the next one or idle.
  always @(posedge clk_i) begin
    logic         took;
    sample_beat_t nxt;
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      took = start && !busy;
      if (took) begin
        beats_accepted++;
        take_sample(value_i, last_i);
      end
      if (!start || took) begin
        if (pending_beats.size() != 0 &&
            $urandom_range(99) >= pending_beats[0].idle_pct) begin
          nxt = pending_beats.pop_front();
          value_i <= nxt.value;
          last_i  <= nxt.last;
          start   <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result is taken at this edge; compare it field by field.
  always @(posedge clk_i) begin
    median_result_t exp_r;
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("end of test: mismatches");
      $finish;
    end else if (rst_ni && done_o) begin
      if (expected_medians.size() == 0) begin
        mismatches++;
        if (mismatches <= ReportMax)
          $display("unexpected result: lower_median %0d in_range %0d candidates %0d ovf %0b",
                   lower_median_o, in_range_count_o, candidate_count_o, overflow_o);
      end else begin
        exp_r = expected_medians.pop_front();
        if (lower_median_o !== exp_r.lower_median) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d lower_median: expected %0d, got %0d",
                     results_checked, exp_r.lower_median, lower_median_o);
        end
        if (in_range_count_o !== exp_r.in_range) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d in_range_count: expected %0d, got %0d",
                     results_checked, exp_r.in_range, in_range_count_o);
        end
        if (candidate_count_o !== exp_r.candidates) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d candidate_count: expected %0d, got %0d",
                     results_checked, exp_r.candidates, candidate_count_o);
        end
        if (overflow_o !== exp_r.overflow) begin
          mismatches++;
          if (mismatches <= ReportMax)
            $display("result %0d overflow: expected %0b, got %0b",
                     results_checked, exp_r.overflow, overflow_o);
        end
        results_checked++;
      end
    end
  end

  function automatic void queue_beat(logic [VBits-1:0] v, logic closes, int unsigned pct);
    sample_beat_t b;
    b.value    = v;
    b.last     = closes;
    b.idle_pct = pct;
    pending_beats.insert(pending_beats.size(), b);
    beats_queued++;
  endfunction

  function automatic logic [VBits-1:0] pick_value(int mode);
    logic [VBits-1:0] v;
    case (mode)
      ValNarrow: begin
        // cluster near either end so duplicates and equal medians are common
        if ($urandom_range(1) == 0) v = VBits'($urandom_range(0, 5));
        else v = VBits'($urandom_range(65530, 65535));
      end
      ValEdge: begin
        case ($urandom_range(5))
          0: v = '0;
          1: v = 'd1;
          2: v = {1'b0, {(VBits-1){1'b1}}};
          3: v = {1'b1, {(VBits-1){1'b0}}};
          4: v = {{(VBits-1){1'b1}}, 1'b0};
          default: v = '1;
        endcase
      end
      default: v = VBits'($urandom());
    endcase
    return v;
  endfunction

  function automatic void queue_set(int unsigned n, int mode, int unsigned pct);
    for (int unsigned i = 0; i < n; i++) queue_beat(pick_value(mode), i == n - 1, pct);
  endfunction

  initial begin
    int unsigned random_items;
    int unsigned n;
    int unsigned pct;
    int unsigned idle_by_phase[4];
    idle_by_phase = '{0, 67, 0, 26};

    // Directed sets: single samples at both ends, widest interval, duplicates,
    // even and odd sizes, one set in reverse order, alternating bit patterns.
    queue_beat(16'h0000, 1'b1, 0);
    queue_beat(16'hFFFF, 1'b1, 0);
    queue_beat(16'h0000, 1'b0, 0);
    queue_beat(16'hFFFF, 1'b1, 0);
    queue_beat(16'd5, 1'b0, 0);
    queue_beat(16'd5, 1'b0, 0);
    queue_beat(16'd5, 1'b1, 0);
    queue_beat(16'd9, 1'b0, 0);
    queue_beat(16'd5, 1'b0, 0);
    queue_beat(16'd3, 1'b0, 0);
    queue_beat(16'd1, 1'b1, 0);
    queue_beat(16'hFFFF, 1'b0, 0);
    queue_beat(16'h0000, 1'b0, 0);
    queue_beat(16'h8000, 1'b0, 0);
    queue_beat(16'h0001, 1'b0, 0);
    queue_beat(16'hFFFE, 1'b1, 0);
    queue_beat(16'd7, 1'b0, 0);
    queue_beat(16'd2, 1'b0, 0);
    queue_beat(16'd7, 1'b0, 0);
    queue_beat(16'd3, 1'b0, 0);
    queue_beat(16'd7, 1'b0, 0);
    queue_beat(16'd3, 1'b1, 0);
    queue_beat(16'hAAAA, 1'b0, 0);
    queue_beat(16'h5555, 1'b1, 0);

    // Random sets, mostly small, walking through the idling phases.
    random_items = 0;
    while (random_items < 150) begin
      pct = idle_by_phase[(random_items / 38) % 4];
      n   = ($urandom_range(9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 12);
      queue_set(n, $urandom_range(ValFull, ValEdge), pct);
      random_items += n;
    end

    // Capacity set: fill the store, then drop one more sample and the closing
    // beat on the full store.
    queue_set(Cap + 2, ValNarrow, 67);
    queue_set(3, ValEdge, 0);

    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Hold until every beat is taken and every result has come back.
    while (beats_accepted != beats_queued || expected_medians.size() != 0)
      @(posedge clk_i);
    repeat (Cap + 8) @(posedge clk_i);
    mismatches += expected_medians.size();

    $display("%0d samples in %0d sets sent, %0d of them overflowing the store",
             beats_accepted, sets_closed, overflow_sets);
    $display("%0d results compared over %0d cycles", results_checked, cycle_count);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
